FILE: src/tvi_pkg.sv
// Shared types, constants and reset values for the triangle VCO integrator.
package tvi_pkg;

  localparam int VOLT_WIDTH  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Q3.12 / Q0.16 constants
  localparam logic [15:0] FRAC_TENTH = 16'd410;    // 0.1 V
  localparam logic [15:0] GAIN_095   = 16'd62259;  // 0.95 in Q0.16
  localparam logic [12:0] ONE_Q12    = 13'd4096;

  // Register reset values
  localparam logic [14:0]        SUPPLY_RESET = 15'd20480;
  localparam logic signed [15:0] STOP_RESET   = -16'sd12534;
  localparam logic signed [15:0] STABLE_RESET = -16'sd6701;
  localparam logic signed [15:0] UPPER_RESET  = -16'sd471;
  localparam logic signed [15:0] LOWER_RESET  = -16'sd2068;
  localparam logic [23:0]        GAIN_RESET   = 24'd0;
  localparam logic [15:0]        RECIP_RESET  = 16'd2876;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SUPPLY = 3'd0,
    REG_STOP   = 3'd1,
    REG_STABLE = 3'd2,
    REG_UPPER  = 3'd3,
    REG_LOWER  = 3'd4,
    REG_GAIN   = 3'd5,
    REG_RECIP  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [14:0]        supply_voltage;
    logic signed [15:0] stop_threshold;
    logic signed [15:0] stable_threshold;
    logic signed [15:0] upper_limit;
    logic signed [15:0] lower_limit;
    logic [23:0]        step_gain;
    logic [15:0]        span_reciprocal;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRIVE,
    ST_FALL,
    ST_FRAC,
    ST_BASE,
    ST_SCALE,
    ST_RISE,
    ST_COMMIT
  } state_t;

  // Which product the shared multiplier forms this cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DRIVE,
    OP_FALL,
    OP_FRAC,
    OP_BASE,
    OP_SCALE,
    OP_RISE
  } mul_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    load;
    mul_op_t op;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/tvi_in_if.sv
// Input channel: one control-voltage word per handshake.
interface tvi_in_if #(
  parameter int VOLT_WIDTH = tvi_pkg::VOLT_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] control_voltage;

  modport source (output valid, output control_voltage, input ready);
  modport sink   (input valid, input control_voltage, output ready);
endinterface

FILE: src/tvi_out_if.sv
// Output channel: one triangle-voltage word per handshake.
interface tvi_out_if #(
  parameter int VOLT_WIDTH = tvi_pkg::VOLT_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] triangle_voltage;

  modport source (output valid, output triangle_voltage, input ready);
  modport sink   (input valid, input triangle_voltage, output ready);
endinterface

FILE: src/triangle_vco_integrator_unit.sv
// Triangle VCO integrator: timing-capacitor model of a function generator, top level.
//
// Takes one signed Q3.12 control-voltage word per handshake on 'sample' and
// returns one triangle-voltage word (the capacitor voltage after that sample)
// on 'result'. Words are handled one at a time: the result of an accepted word
// sits in the output register after six passes through the single shared
// multiplier and the commit state, and the input opens again on the cycle
// after the commit, so a new word is only taken once the previous one has
// been committed. The output register lets a new word be accepted while the
// previous result still waits; the commit cycle stalls until that result has
// been taken. Halted samples (control at or below the stop threshold, or no
// headroom to the supply) leave the state untouched and return the held voltage.
// Configuration registers are written through cfg_write/cfg_index/cfg_data and
// must only be changed while the block is idle; unmapped indexes are ignored.
module triangle_vco_integrator_unit #(
  parameter int VOLT_WIDTH = tvi_pkg::VOLT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tvi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tvi_pkg::CFG_DATA_W-1:0]  cfg_data,
  tvi_in_if.sink                          sample,
  tvi_out_if.source                       result
);

  tvi_pkg::cfg_t       cfg;
  tvi_pkg::dp_cmd_t    ctrl_cmd;
  tvi_pkg::dp_status_t dp_status;

  // register file
  tvi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> six multiplier steps -> commit
  tvi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (dp_status),
    .cmd    (ctrl_cmd)
  );

  // arithmetic, capacitor state and output register
  tvi_dp #(
    .VOLT_WIDTH (VOLT_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (ctrl_cmd),
    .status (dp_status),
    .sample (sample),
    .result (result)
  );

  // A word just taken keeps the input closed while it is worked on.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("input accepted again straight after a load");

  // A fresh result only ever follows a commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(ctrl_cmd.commit))
    else $error("result word appeared without a commit");

  // Never overwrite a result that is still waiting.
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.commit |-> (!result.valid || result.ready))
    else $error("commit over an untaken result word");

endmodule

FILE: src/tvi_cfg_regs.sv
// Configuration register file, written through a plain write port.
module tvi_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tvi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tvi_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tvi_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply_voltage   <= tvi_pkg::SUPPLY_RESET;
      cfg.stop_threshold   <= tvi_pkg::STOP_RESET;
      cfg.stable_threshold <= tvi_pkg::STABLE_RESET;
      cfg.upper_limit      <= tvi_pkg::UPPER_RESET;
      cfg.lower_limit      <= tvi_pkg::LOWER_RESET;
      cfg.step_gain        <= tvi_pkg::GAIN_RESET;
      cfg.span_reciprocal  <= tvi_pkg::RECIP_RESET;
    end else if (cfg_write) begin
      unique case (tvi_pkg::reg_index_t'(cfg_index))
        tvi_pkg::REG_SUPPLY: cfg.supply_voltage   <= cfg_data[14:0];
        tvi_pkg::REG_STOP:   cfg.stop_threshold   <= cfg_data[15:0];
        tvi_pkg::REG_STABLE: cfg.stable_threshold <= cfg_data[15:0];
        tvi_pkg::REG_UPPER:  cfg.upper_limit      <= cfg_data[15:0];
        tvi_pkg::REG_LOWER:  cfg.lower_limit      <= cfg_data[15:0];
        tvi_pkg::REG_GAIN:   cfg.step_gain        <= cfg_data[23:0];
        tvi_pkg::REG_RECIP:  cfg.span_reciprocal  <= cfg_data[15:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

FILE: src/tvi_ctrl.sv
// Sequencer: steps one word through the shared multiplier and commits it.
module tvi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  tvi_pkg::dp_status_t status,
  output tvi_pkg::dp_cmd_t    cmd
);

  tvi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tvi_pkg::ST_IDLE:   if (status.in_valid) state_next = tvi_pkg::ST_DRIVE;
      tvi_pkg::ST_DRIVE:  state_next = tvi_pkg::ST_FALL;
      tvi_pkg::ST_FALL:   state_next = tvi_pkg::ST_FRAC;
      tvi_pkg::ST_FRAC:   state_next = tvi_pkg::ST_BASE;
      tvi_pkg::ST_BASE:   state_next = tvi_pkg::ST_SCALE;
      tvi_pkg::ST_SCALE:  state_next = tvi_pkg::ST_RISE;
      tvi_pkg::ST_RISE:   state_next = tvi_pkg::ST_COMMIT;
      tvi_pkg::ST_COMMIT: if (status.out_free) state_next = tvi_pkg::ST_IDLE;
      default:            state_next = tvi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.load     = 1'b0;
    cmd.op       = tvi_pkg::OP_NONE;
    cmd.commit   = 1'b0;
    unique case (state)
      tvi_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = status.in_valid;
      end
      tvi_pkg::ST_DRIVE:  cmd.op = tvi_pkg::OP_DRIVE;
      tvi_pkg::ST_FALL:   cmd.op = tvi_pkg::OP_FALL;
      tvi_pkg::ST_FRAC:   cmd.op = tvi_pkg::OP_FRAC;
      tvi_pkg::ST_BASE:   cmd.op = tvi_pkg::OP_BASE;
      tvi_pkg::ST_SCALE:  cmd.op = tvi_pkg::OP_SCALE;
      tvi_pkg::ST_RISE:   cmd.op = tvi_pkg::OP_RISE;
      tvi_pkg::ST_COMMIT: cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: src/tvi_dp.sv
// Datapath: operand capture, shared multiplier, capacitor update, output register.
module tvi_dp #(
  parameter int VOLT_WIDTH = tvi_pkg::VOLT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  tvi_pkg::cfg_t       cfg,
  input  tvi_pkg::dp_cmd_t    cmd,
  output tvi_pkg::dp_status_t status,
  tvi_in_if.sink              sample,
  tvi_out_if.source           result
);

  localparam int XW = ((VOLT_WIDTH > 16) ? VOLT_WIDTH : 16) + 3;  // signed load width
  localparam int UW = XW - 1;                                     // unsigned magnitudes
  localparam int PW = UW + 24;                                    // product width
  localparam int AW = XW + 2;                                     // update width

  localparam logic signed [AW-1:0] V_MAX =
    {{(AW-VOLT_WIDTH+1){1'b0}}, {(VOLT_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] V_MIN =
    {{(AW-VOLT_WIDTH+1){1'b1}}, {(VOLT_WIDTH-1){1'b0}}};

  // load stage
  logic signed [XW-1:0] cv_x, supply_x, stop_x, stable_x, tenth_x, vch, diff, base;

  logic signed [VOLT_WIDTH-1:0] cv_q;
  logic [UW-1:0]                vch_q;
  logic [UW-1:0]                diff_q;
  logic [15:0]                  base_q;
  logic                         active_q, reduced_q;

  // multiplier results
  logic [UW-1:0] drive_q, fall_q, rise_q;
  logic [12:0]   factor_q;
  logic [15:0]   b95_q, b2_q;

  logic [UW-1:0] mul_a;
  logic [23:0]   mul_b;
  logic [PW-1:0] prod;

  // state
  logic signed [VOLT_WIDTH-1:0] cap_voltage;
  logic                         discharging;
  logic                         out_valid;
  logic signed [VOLT_WIDTH-1:0] out_data;

  // update stage
  logic signed [AW-1:0]         cap_a, cv_a, upper_a, lower_a, fall_a, rise_a, v;
  logic                         dis_next;
  logic signed [VOLT_WIDTH-1:0] v_sat;

  assign status.in_valid = sample.valid;
  assign status.out_free = !out_valid || result.ready;
  assign sample.ready    = cmd.in_ready;
  assign result.valid    = out_valid;
  assign result.triangle_voltage = out_data;

  always_comb begin
    cv_x     = {{(XW-VOLT_WIDTH){sample.control_voltage[VOLT_WIDTH-1]}},
                sample.control_voltage};
    supply_x = {{(XW-15){1'b0}}, cfg.supply_voltage};
    stop_x   = {{(XW-16){cfg.stop_threshold[15]}}, cfg.stop_threshold};
    stable_x = {{(XW-16){cfg.stable_threshold[15]}}, cfg.stable_threshold};
    tenth_x  = {{(XW-16){1'b0}}, tvi_pkg::FRAC_TENTH};
    vch      = supply_x - cv_x - tenth_x;
    diff     = stable_x - cv_x;
    base     = supply_x - stable_x - tenth_x;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cv_q      <= sample.control_voltage;
      vch_q     <= vch[UW-1:0];
      diff_q    <= diff[UW-1:0];        // only used while control < stable
      base_q    <= (base < 0) ? 16'd0 : base[15:0];
      active_q  <= (cv_x > stop_x) && (vch > 0);
      reduced_q <= cv_x < stable_x;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      tvi_pkg::OP_DRIVE: begin
        mul_a = vch_q;
        mul_b = {8'd0, tvi_pkg::GAIN_095};
      end
      tvi_pkg::OP_FALL: begin
        mul_a = drive_q;
        mul_b = cfg.step_gain;
      end
      tvi_pkg::OP_FRAC: begin
        mul_a = diff_q;
        mul_b = {8'd0, cfg.span_reciprocal};
      end
      tvi_pkg::OP_BASE: begin
        mul_a = {{(UW-16){1'b0}}, base_q};
        mul_b = {8'd0, tvi_pkg::GAIN_095};
      end
      tvi_pkg::OP_SCALE: begin
        mul_a = {{(UW-16){1'b0}}, b95_q};
        mul_b = {11'd0, factor_q};
      end
      tvi_pkg::OP_RISE: begin
        mul_a = {{(UW-16){1'b0}}, b2_q};
        mul_b = cfg.step_gain;
      end
      tvi_pkg::OP_NONE: ;
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tvi_pkg::OP_DRIVE: drive_q <= prod[16 +: UW];
      tvi_pkg::OP_FALL:  fall_q  <= prod[24 +: UW];
      tvi_pkg::OP_FRAC:  factor_q <=
        (prod[PW-1:12] > {{(PW-25){1'b0}}, tvi_pkg::ONE_Q12}) ? 13'd0
                                                             : tvi_pkg::ONE_Q12 - prod[24:12];
      tvi_pkg::OP_BASE:  b95_q   <= prod[16 +: 16];
      tvi_pkg::OP_SCALE: b2_q    <= prod[12 +: 16];
      tvi_pkg::OP_RISE:  rise_q  <= prod[24 +: UW];
      tvi_pkg::OP_NONE: ;
      default: ;
    endcase
  end

  // capacitor update
  always_comb begin
    cap_a   = {{(AW-VOLT_WIDTH){cap_voltage[VOLT_WIDTH-1]}}, cap_voltage};
    cv_a    = {{(AW-VOLT_WIDTH){cv_q[VOLT_WIDTH-1]}}, cv_q};
    upper_a = {{(AW-16){cfg.upper_limit[15]}}, cfg.upper_limit};
    lower_a = {{(AW-16){cfg.lower_limit[15]}}, cfg.lower_limit};
    fall_a  = {{(AW-UW){1'b0}}, fall_q};
    rise_a  = reduced_q ? {{(AW-UW){1'b0}}, rise_q} : fall_a;
    v        = cap_a;
    dis_next = discharging;
    if (active_q) begin
      if (discharging) begin
        v = cap_a - fall_a;
        if (v < lower_a) begin
          v        = lower_a;
          dis_next = 1'b0;
        end
      end else begin
        v = cap_a + rise_a;
        if (v > cv_a) v = cv_a;
        if (v > upper_a) begin
          v        = (upper_a <<< 1) - v;  // reflect the overshoot
          dis_next = 1'b1;
          if (v < lower_a) begin
            v        = lower_a;
            dis_next = 1'b0;
          end
        end
      end
    end
    if (v > V_MAX)      v_sat = V_MAX[VOLT_WIDTH-1:0];
    else if (v < V_MIN) v_sat = V_MIN[VOLT_WIDTH-1:0];
    else                v_sat = v[VOLT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_voltage <= '0;
      discharging <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cap_voltage <= v_sat;
        discharging <= dis_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= v_sat;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the triangle VCO integrator: waveform scoreboard class and stimulus top module.
`timescale 1ns / 1ps

// Tracks the capacitor as the block should, one expected triangle word per
// accepted control word, and compares results in order.
class tri_wave_scoreboard;
  localparam int VW = tvi_pkg::VOLT_WIDTH;

  logic [14:0]          supply;
  logic signed [15:0]   stop_th;
  logic signed [15:0]   stable_th;
  logic signed [15:0]   upper;
  logic signed [15:0]   lower;
  logic [23:0]          gain;
  logic [15:0]          recip;
  logic signed [VW-1:0] cap;
  bit                   falling;
  logic signed [VW-1:0] expected_q[$];
  int                   errors;

  function new();
    supply    = tvi_pkg::SUPPLY_RESET;
    stop_th   = tvi_pkg::STOP_RESET;
    stable_th = tvi_pkg::STABLE_RESET;
    upper     = tvi_pkg::UPPER_RESET;
    lower     = tvi_pkg::LOWER_RESET;
    gain      = tvi_pkg::GAIN_RESET;
    recip     = tvi_pkg::RECIP_RESET;
    cap       = '0;
    falling   = 1'b0;
    errors    = 0;
  endfunction

  function void write_reg(logic [tvi_pkg::CFG_INDEX_W-1:0] idx,
                          logic [tvi_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tvi_pkg::REG_SUPPLY: supply    = data[14:0];
      tvi_pkg::REG_STOP:   stop_th   = data[15:0];
      tvi_pkg::REG_STABLE: stable_th = data[15:0];
      tvi_pkg::REG_UPPER:  upper     = data[15:0];
      tvi_pkg::REG_LOWER:  lower     = data[15:0];
      tvi_pkg::REG_GAIN:   gain      = data[23:0];
      tvi_pkg::REG_RECIP:  recip     = data[15:0];
      default: ;
    endcase
  endfunction

  // Capacitor voltage after one control sample; updates the tracked state.
  function logic signed [VW-1:0] next_voltage(logic signed [VW-1:0] cv);
    longint c, sup, stp, stb, up, lo, g, rc, tenth, k095, one;
    longint vch, drive, fall, rise, v, base, frac, factor, vmax, vmin;
    c     = longint'(cv);
    sup   = longint'(supply);
    stp   = longint'(stop_th);
    stb   = longint'(stable_th);
    up    = longint'(upper);
    lo    = longint'(lower);
    g     = longint'(gain);
    rc    = longint'(recip);
    tenth = longint'(tvi_pkg::FRAC_TENTH);
    k095  = longint'(tvi_pkg::GAIN_095);
    one   = longint'(tvi_pkg::ONE_Q12);
    vmax  = (longint'(1) <<< (VW - 1)) - 1;
    vmin  = -vmax - 1;
    vch   = sup - c - tenth;
    if (c > stp && vch > 0) begin
      drive = (vch * k095) >> 16;
      fall  = (drive * g) >> 24;
      rise  = fall;
      v     = longint'(cap);
      // below the stable threshold the charge rate tapers off linearly
      if (c < stb) begin
        base = sup - stb - tenth;
        frac = ((stb - c) * rc) >> 12;
        if (base < 0) base = 0;
        if (frac > one) frac = one;
        factor = one - frac;
        base   = (base * k095) >> 16;
        base   = (base * factor) >> 12;
        rise   = (base * g) >> 24;
      end
      if (falling) begin
        v = v - fall;
        if (v < lo) begin
          v       = lo;
          falling = 1'b0;
        end
      end else begin
        v = v + rise;
        if (v > c) v = c;
        if (v > up) begin
          v       = up - (v - up);
          falling = 1'b1;
          if (v < lo) begin
            v       = lo;
            falling = 1'b0;
          end
        end
      end
      if (v > vmax) v = vmax;
      if (v < vmin) v = vmin;
      cap = VW'(v);
    end
    return cap;
  endfunction

  function void note_word(logic signed [VW-1:0] cv);
    expected_q.push_back(next_voltage(cv));
  endfunction

  function void check_word(logic signed [VW-1:0] got);
    logic signed [VW-1:0] want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected triangle_voltage word, expected none, actual %0d", $time, got);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: triangle_voltage mismatch, expected %0d, actual %0d", $time, want, got);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam int IW = tvi_pkg::CFG_INDEX_W;
  localparam int DW = tvi_pkg::CFG_DATA_W;
  // index that maps to no register; writes to it must be ignored
  localparam logic [IW-1:0] REG_UNMAPPED = 3'd7;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 160;

  logic          clk;
  logic          rst;
  logic          cfg_write;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  tvi_in_if  sample_ch();
  tvi_out_if result_ch();

  triangle_vco_integrator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  tri_wave_scoreboard sb;

  bit calm;    // set for the final stretch: no idling on either side
  int cv_lo;   // range that most control words of a phase are drawn from
  int cv_hi;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly in-range words for the current phase, the rest raw 16-bit noise.
  function int next_cv();
    logic signed [15:0] raw;
    raw = 16'($urandom);
    if ($urandom_range(0, 4) == 0) return int'(raw);
    return pick(cv_lo, cv_hi);
  endfunction

  // Called at a falling edge; leaves the write strobe high until the next one.
  task write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Writes every register; junk above each register's width must be dropped.
  task load_setup(input int sup, input int stp, input int stb, input int up,
                  input int lo, input int g, input int rc);
    logic [23:0] junk;
    junk = 24'($urandom);
    if (junk[0]) write_reg(REG_UNMAPPED, DW'($urandom));
    write_reg(tvi_pkg::REG_SUPPLY, {junk[23:15], sup[14:0]});
    write_reg(tvi_pkg::REG_STOP,   {junk[7:0], stp[15:0]});
    write_reg(tvi_pkg::REG_STABLE, {junk[15:8], stb[15:0]});
    write_reg(tvi_pkg::REG_UPPER,  {junk[23:16], up[15:0]});
    write_reg(tvi_pkg::REG_LOWER,  {~junk[7:0], lo[15:0]});
    write_reg(tvi_pkg::REG_GAIN,   g[23:0]);
    write_reg(tvi_pkg::REG_RECIP,  {junk[11:4], rc[15:0]});
    if (!junk[0]) write_reg(REG_UNMAPPED, DW'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Drops valid, then waits at falling edges until every word has come back.
  task drain();
    sample_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Presents one control word from a falling edge, returns at the falling
  // edge after it was taken, with valid still high.
  task send_word(input int cv);
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.control_voltage <= cv[15:0];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_word(cv[15:0]);
    @(negedge clk);
  endtask

  // kind 0: every register at an extreme; 1: anything; 2: a sensible
  // oscillator with random shape, so the triangle actually runs.
  task random_setup(input int kind);
    int sup, stp, stb, up, lo, g, rc;
    case (kind)
      0: begin
        sup = $urandom_range(0, 1) ? 32767 : 0;
        stp = $urandom_range(0, 1) ? 32767 : -32768;
        stb = $urandom_range(0, 1) ? 32767 : -32768;
        up  = $urandom_range(0, 1) ? 32767 : -32768;
        lo  = $urandom_range(0, 1) ? 32767 : -32768;
        g   = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
        rc  = $urandom_range(0, 1) ? 65535 : 0;
        cv_lo = -32768;
        cv_hi = 32767;
      end
      1: begin
        sup = int'($urandom_range(0, 32767));
        stp = pick(-32768, 32767);
        stb = pick(-32768, 32767);
        up  = pick(-32768, 32767);
        lo  = pick(-32768, 32767);
        g   = int'($urandom_range(0, 24'hFFFFFF));
        rc  = int'($urandom_range(0, 65535));
        cv_lo = -32768;
        cv_hi = 32767;
      end
      default: begin
        sup = pick(8192, 32767);
        stp = pick(-16000, -4000);
        stb = stp + pick(500, 8000);
        up  = stb + pick(-2000, 6000);
        lo  = up - pick(100, 6000);
        g   = pick(1 << 14, 1 << 22);
        rc  = 16777216 / (stb - stp);
        if (rc > 65535) rc = 65535;
        if ($urandom_range(0, 7) == 0) rc = int'($urandom_range(0, 65535));
        cv_lo = stp - 300;
        cv_hi = up + 5000;
      end
    endcase
    load_setup(sup, stp, stb, up, lo, g, rc);
  endtask

  // Result side: random stall bursts, none in the calm stretch.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        result_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = int'($urandom_range(0, 10));
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Result words are sampled at the rising edge, as the block sees them.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_word(result_ch.triangle_voltage);
  end

  initial begin
    // defaults, then overshoot and clamping runs from the oscillator proper
    int list_a[12] = '{-12533, -6702, -6701, 20069, 20070, -12534, 0, 0, 0, 0, 0, 0};
    // factor overrun, reflection falling below the lower limit, no headroom
    int list_b[5]  = '{-1000, 20000, 20000, 32767, -32767};
    // supply at zero: reduced drive negative, halting at stop and headroom
    int list_c[5]  = '{-32768, -32767, -5000, -411, -410};
    sb = new();
    calm = 1'b0;
    cv_lo = -32768;
    cv_hi = 32767;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.control_voltage = '0;
    result_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero gain, so the capacitor must sit at zero volts.
    send_word(-32768);
    send_word(32767);
    drain();

    load_setup(int'(tvi_pkg::SUPPLY_RESET), int'(tvi_pkg::STOP_RESET),
               int'(tvi_pkg::STABLE_RESET), int'(tvi_pkg::UPPER_RESET),
               int'(tvi_pkg::LOWER_RESET), 32'h0040_0000, int'(tvi_pkg::RECIP_RESET));
    foreach (list_a[i]) send_word(list_a[i]);
    drain();

    load_setup(32767, -32768, 0, 1000, 900, 32'h00FF_FFFF, 65535);
    foreach (list_b[i]) send_word(list_b[i]);
    drain();

    load_setup(0, -32768, 32767, 32767, -32768, 32'h00FF_FFFF, 0);
    foreach (list_c[i]) send_word(list_c[i]);
    drain();

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      random_setup((p == 1 || p == 7) ? 0 : (p == 2 ? 1 : 2));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(next_cv());
        // sender holds off mid-phase until the pipeline has emptied
        if (p == 4 && n == PHASE_WORDS / 2) drain();
      end
      drain();
    end

    repeat (16) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
